[hw/rtl/csot_pkg.sv]
`default_nettype none

package csot_pkg;

  // Quotient fraction bits of the projection parameter t
  localparam int unsigned T_BITS = 16;

  // Coordinate and derived widths
  localparam int unsigned CRD_W = 32;              // Q16.16 coordinate
  localparam int unsigned RAD_W = 31;              // unsigned radius
  localparam int unsigned DIF_W = CRD_W + 1;       // difference of two coordinates
  localparam int unsigned PRD_W = 2 * DIF_W;       // signed product of two differences
  localparam int unsigned SQ_W  = 2 * CRD_W + 1;   // square of a difference
  localparam int unsigned NUM_W = PRD_W + 1;       // sum of three products
  localparam int unsigned DEN_W = SQ_W + 1;        // sum of three squares
  localparam int unsigned REM_W = DEN_W;           // divider remainder
  localparam int unsigned TQ_W  = T_BITS + 1;      // t in 0..1, inclusive
  localparam int unsigned OFF_W = TQ_W + 1 + DIF_W; // t times a difference
  localparam int unsigned RSUM_W = RAD_W + 1;      // sum of both radii
  localparam int unsigned RSQ_W  = 2 * RSUM_W;
  localparam int unsigned DST_W  = SQ_W + 2;       // sum of three squared distances

  // Configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = CRD_W;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_R  = 3'd6;

  // Pipeline depth: three front stages, setup, T_BITS divide steps,
  // offset product, difference, squares, result
  localparam int unsigned N_STG = T_BITS + 8;

  typedef struct packed {
    logic [2:0][DIF_W-1:0] w;
    logic [2:0][DIF_W-1:0] d;
    logic [RSUM_W-1:0]     rsum;
  } stg_a_t;

  typedef struct packed {
    logic [2:0][PRD_W-1:0] pw;
    logic [2:0][SQ_W-1:0]  dd;
    logic [2:0][DIF_W-1:0] w;
    logic [2:0][DIF_W-1:0] d;
    logic [RSUM_W-1:0]     rsum;
  } stg_b_t;

  typedef struct packed {
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
    logic [2:0][DIF_W-1:0] w;
    logic [2:0][DIF_W-1:0] d;
    logic [RSUM_W-1:0]     rsum;
  } stg_c_t;

  typedef struct packed {
    logic [REM_W-1:0]      rem;
    logic [DEN_W-1:0]      den;
    logic [T_BITS-1:0]     q;
    logic                  zero;
    logic                  one;
    logic [2:0][DIF_W-1:0] w;
    logic [2:0][DIF_W-1:0] d;
    logic [RSUM_W-1:0]     rsum;
  } stg_div_t;

  typedef struct packed {
    logic [2:0][OFF_W-1:0] prod;
    logic [2:0][DIF_W-1:0] w;
    logic [RSUM_W-1:0]     rsum;
  } stg_e_t;

  typedef struct packed {
    logic [2:0][DIF_W-1:0] diff;
    logic [RSUM_W-1:0]     rsum;
  } stg_g_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] sq;
    logic [RSQ_W-1:0]     rsq;
  } stg_h_t;

endpackage

`default_nettype wire

[hw/rtl/csot_if.sv]
`default_nettype none

// Sphere word channel
interface csot_sphere_if;
  import csot_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic signed [CRD_W-1:0] center_z;
  logic [RAD_W-1:0]        sphere_radius;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink   (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

// Overlap result word channel
interface csot_result_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

`default_nettype wire

[hw/rtl/csot_div_step.sv]
`default_nettype none

// One restoring division step: shift the remainder, subtract the divisor
// when it fits, and append the quotient bit.
module csot_div_step
  import csot_pkg::*;
(
  input  wire logic [REM_W-1:0]  rem_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [T_BITS-1:0] q_i,
  output logic      [REM_W-1:0]  rem_o,
  output logic      [T_BITS-1:0] q_o
);

  logic [REM_W:0] rem2;
  logic [REM_W:0] diff;
  logic           fits;

  always_comb begin
    rem2 = {rem_i, 1'b0};
    diff = rem2 - {1'b0, den_i};
    fits = (rem2 >= {1'b0, den_i});
    rem_o = fits ? diff[REM_W-1:0] : rem2[REM_W-1:0];
    q_o   = {q_i[T_BITS-2:0], fits};
  end

endmodule

`default_nettype wire

[hw/rtl/capsule_sphere_overlap_test_top.sv]
`default_nettype none

// Channel   Dir  Fields                                        Handshake
// sphere_i  in   center_x/y/z (s32), sphere_radius (u31)       valid/ready
// result_o  out  overlap (1)                                   valid/ready
// cfg       in   cfg_we_i, cfg_idx_i (3), cfg_wdata_i (32)     write enable only
//
// Fully pipelined: one sphere word per cycle unless the output stalls.
// The depth is set by the T_BITS-step restoring divider that forms the
// projection parameter t. Each stage holds while the stage after it is
// full and stalled; bubbles are squeezed out. Reset clears the capsule
// registers and all valid bits.
module capsule_sphere_overlap_test_top
  import csot_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  csot_sphere_if.sink               sphere_i,
  csot_result_if.source             result_o
);

  // Capsule registers
  logic [2:0][CRD_W-1:0] base_q;
  logic [2:0][CRD_W-1:0] top_q;
  logic [RAD_W-1:0]      crad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      top_q  <= '0;
      crad_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_X: base_q[0] <= cfg_wdata_i;
        REG_BASE_Y: base_q[1] <= cfg_wdata_i;
        REG_BASE_Z: base_q[2] <= cfg_wdata_i;
        REG_TOP_X:  top_q[0]  <= cfg_wdata_i;
        REG_TOP_Y:  top_q[1]  <= cfg_wdata_i;
        REG_TOP_Z:  top_q[2]  <= cfg_wdata_i;
        REG_CAP_R:  crad_q    <= cfg_wdata_i[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Stage control: a stage advances when empty or when its successor advances
  logic [N_STG-1:0] vld_q;
  logic [N_STG-1:0] adv;

  always_comb begin
    adv[N_STG-1] = !vld_q[N_STG-1] || result_o.ready;
    for (int k = N_STG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= sphere_i.valid;
      end
      for (int k = 1; k < N_STG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign sphere_i.ready = adv[0];
  assign result_o.valid = vld_q[N_STG-1];

  // Stage A: center and segment end relative to base, radius sum
  stg_a_t a_d, a_q;
  logic [2:0][CRD_W-1:0] cen;

  always_comb begin
    cen[0] = sphere_i.center_x;
    cen[1] = sphere_i.center_y;
    cen[2] = sphere_i.center_z;
    for (int i = 0; i < 3; i++) begin
      a_d.w[i] = {cen[i][CRD_W-1], cen[i]} - {base_q[i][CRD_W-1], base_q[i]};
      a_d.d[i] = {top_q[i][CRD_W-1], top_q[i]} - {base_q[i][CRD_W-1], base_q[i]};
    end
    a_d.rsum = {1'b0, crad_q} + {1'b0, sphere_i.sphere_radius};
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a_q <= a_d;
    end
  end

  // Stage B: per-axis products w.d and d.d
  stg_b_t b_d, b_q;
  logic signed [PRD_W-1:0] dsq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_d.pw[i] = $signed(a_q.w[i]) * $signed(a_q.d[i]);
      dsq[i]    = $signed(a_q.d[i]) * $signed(a_q.d[i]);
      b_d.dd[i] = dsq[i][SQ_W-1:0];
    end
    b_d.w    = a_q.w;
    b_d.d    = a_q.d;
    b_d.rsum = a_q.rsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      b_q <= b_d;
    end
  end

  // Stage C: projection numerator and denominator
  stg_c_t c_d, c_q;

  always_comb begin
    c_d.num = {b_q.pw[0][PRD_W-1], b_q.pw[0]}
            + {b_q.pw[1][PRD_W-1], b_q.pw[1]}
            + {b_q.pw[2][PRD_W-1], b_q.pw[2]};
    c_d.den = {1'b0, b_q.dd[0]} + {1'b0, b_q.dd[1]} + {1'b0, b_q.dd[2]};
    c_d.w    = b_q.w;
    c_d.d    = b_q.d;
    c_d.rsum = b_q.rsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      c_q <= c_d;
    end
  end

  // Stage D: clamp cases and divider setup
  stg_div_t div_q [T_BITS+1];
  stg_div_t dsu_d;
  logic     num_pos;

  always_comb begin
    num_pos    = !c_q.num[NUM_W-1] && (c_q.num != '0);
    dsu_d.zero = (c_q.den == '0) || !num_pos;
    dsu_d.one  = (c_q.num[DEN_W-1:0] >= c_q.den);
    dsu_d.rem  = c_q.num[REM_W-1:0];
    dsu_d.den  = c_q.den;
    dsu_d.q    = '0;
    dsu_d.w    = c_q.w;
    dsu_d.d    = c_q.d;
    dsu_d.rsum = c_q.rsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      div_q[0] <= dsu_d;
    end
  end

  // Divider: one quotient bit per stage
  for (genvar k = 1; k <= T_BITS; k++) begin : g_div
    logic [REM_W-1:0]  rem_nx;
    logic [T_BITS-1:0] q_nx;
    stg_div_t          div_d;

    csot_div_step u_step (
      .rem_i (div_q[k-1].rem),
      .den_i (div_q[k-1].den),
      .q_i   (div_q[k-1].q),
      .rem_o (rem_nx),
      .q_o   (q_nx)
    );

    // Carry the word forward with the new remainder and quotient
    always_comb begin
      div_d     = div_q[k-1];
      div_d.rem = rem_nx;
      div_d.q   = q_nx;
    end

    always_ff @(posedge clk_i) begin
      if (adv[3+k]) begin
        div_q[k] <= div_d;
      end
    end
  end

  // Stage E: resolve t and scale the segment direction
  stg_e_t e_d, e_q;
  logic [TQ_W-1:0] t_val;

  always_comb begin
    if (div_q[T_BITS].zero) begin
      t_val = '0;
    end else if (div_q[T_BITS].one) begin
      t_val = {1'b1, {T_BITS{1'b0}}};
    end else begin
      t_val = {1'b0, div_q[T_BITS].q};
    end
    for (int i = 0; i < 3; i++) begin
      e_d.prod[i] = $signed({1'b0, t_val}) * $signed(div_q[T_BITS].d[i]);
    end
    e_d.w    = div_q[T_BITS].w;
    e_d.rsum = div_q[T_BITS].rsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4+T_BITS]) begin
      e_q <= e_d;
    end
  end

  // Stage G: floor the offset and subtract the center (p - c)
  stg_g_t g_d, g_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_d.diff[i] = e_q.prod[i][T_BITS +: DIF_W] - e_q.w[i];
    end
    g_d.rsum = e_q.rsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[5+T_BITS]) begin
      g_q <= g_d;
    end
  end

  // Stage H: squared distances and squared radius sum
  stg_h_t h_d, h_q;
  logic signed [PRD_W-1:0] dfsq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dfsq[i]   = $signed(g_q.diff[i]) * $signed(g_q.diff[i]);
      h_d.sq[i] = dfsq[i][SQ_W-1:0];
    end
    h_d.rsq = g_q.rsum * g_q.rsum;
  end

  always_ff @(posedge clk_i) begin
    if (adv[6+T_BITS]) begin
      h_q <= h_d;
    end
  end

  // Result stage: compare, equality counts as overlap
  logic [DST_W-1:0] dist_sum;
  logic             ovl_d, ovl_q;

  always_comb begin
    dist_sum = {2'b00, h_q.sq[0]} + {2'b00, h_q.sq[1]} + {2'b00, h_q.sq[2]};
    ovl_d    = (dist_sum <= {{(DST_W-RSQ_W){1'b0}}, h_q.rsq});
  end

  always_ff @(posedge clk_i) begin
    if (adv[N_STG-1]) begin
      ovl_q <= ovl_d;
    end
  end

  assign result_o.overlap = ovl_q;

endmodule

`default_nettype wire
